// File: hw/rtl/hkrb_pkg.sv
// Shared types, constants and a helper function for the HID keyboard report builder.
package hkrb_pkg;

    localparam int KEY_SLOTS_DEF    = 6;
    localparam int BITMAP_BYTES_DEF = 15;
    localparam int BOOT_BYTES       = 8;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_USAGE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ID   = 1'b1;

    localparam logic [7:0] FIRST_USAGE_RST = 8'd4;
    localparam logic [7:0] REPORT_ID_RST   = 8'd6;

    typedef enum logic [2:0] {
        ACT_KEY_DOWN    = 3'd0,
        ACT_KEY_UP      = 3'd1,
        ACT_CLEAR_KEYS  = 3'd2,
        ACT_ADD_MODS    = 3'd3,
        ACT_REMOVE_MODS = 3'd4,
        ACT_SET_MODS    = 3'd5,
        ACT_SEND        = 3'd6,
        ACT_STATUS      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_BOOT   = 2'd1,
        KIND_BITMAP = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_STATUS,
        ST_CMP,
        ST_BOOT,
        ST_BM
    } t_state;

    typedef struct packed {
        logic  latch;
        logic  exec;
        logic  idx_clr;
        logic  idx_inc;
        logic  scan_step;
        logic  cmp_step;
        logic  emit;
        t_kind emit_kind;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    out_free;
        logic    boot_diff;
        logic    bm_diff;
        logic    scan_end;
        logic    boot_end;
        logic    bm_end;
    } t_dp_sts;

    // Position of the most significant set bit; zero for an empty byte.
    function automatic logic [2:0] high_bit(input logic [7:0] v);
        logic [2:0] hb;
        hb = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                hb = 3'(i);
            end
        end
        return hb;
    endfunction

endpackage

// File: hw/rtl/hkrb_in_if.sv
// Input channel carrying keyboard events with a valid/ready handshake.
interface hkrb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] key_code;
    logic [7:0] mod_bits;

    modport source (output valid, output action, output key_code, output mod_bits,
                    input ready);
    modport sink   (input valid, input action, input key_code, input mod_bits,
                    output ready);
endinterface

// File: hw/rtl/hkrb_out_if.sv
// Output channel carrying report bytes and status results with a valid/ready handshake.
interface hkrb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_kind;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic       last_of_run;
    logic [3:0] key_count;
    logic [7:0] first_key;
    logic       key_pressed;
    logic [7:0] mods;

    modport source (output valid, output result_kind, output byte_index, output byte_value,
                    output last_of_run, output key_count, output first_key,
                    output key_pressed, output mods, input ready);
    modport sink   (input valid, input result_kind, input byte_index, input byte_value,
                    input last_of_run, input key_count, input first_key,
                    input key_pressed, input mods, output ready);
endinterface

// File: hw/rtl/hid_keyboard_report_builder.sv
// A key or modifier event is latched on its transfer, then executed in the execute state.
// A status query scans the bitmap (one bitmap byte scanned per cycle), then gives its result.
// A send compares the report copies, then gives one report byte per cycle for each
// changed report (8 boot bytes, BITMAP_BYTES + 1 rollover bytes) as the output takes them.
// One event is in work at a time; the output register lets the next transfer in meanwhile.
// Reset is synchronous and active low: keys, bitmap, mods and report copies clear, config to 4/6.
module hid_keyboard_report_builder #(
    parameter int KEY_SLOTS    = hkrb_pkg::KEY_SLOTS_DEF,
    parameter int BITMAP_BYTES = hkrb_pkg::BITMAP_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hkrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    hkrb_in_if.sink                        i_key_if,
    hkrb_out_if.source                     o_res_if
);
    import hkrb_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    hkrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key_if.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hkrb_dp #(
        .KEY_SLOTS    (KEY_SLOTS),
        .BITMAP_BYTES (BITMAP_BYTES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_action       (i_key_if.action),
        .i_in_key_code     (i_key_if.key_code),
        .i_in_mod_bits     (i_key_if.mod_bits),
        .i_out_ready       (o_res_if.ready),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_valid       (o_res_if.valid),
        .o_out_kind        (o_res_if.result_kind),
        .o_out_byte_index  (o_res_if.byte_index),
        .o_out_byte_value  (o_res_if.byte_value),
        .o_out_last        (o_res_if.last_of_run),
        .o_out_key_count   (o_res_if.key_count),
        .o_out_first_key   (o_res_if.first_key),
        .o_out_key_pressed (o_res_if.key_pressed),
        .o_out_mods        (o_res_if.mods)
    );

    assign i_key_if.ready = w_in_ready;

endmodule

// File: hw/rtl/hkrb_dp.sv
// Datapath of the report builder: key slots, rollover bitmap, report copies and output register.
module hkrb_dp #(
    parameter int KEY_SLOTS    = hkrb_pkg::KEY_SLOTS_DEF,
    parameter int BITMAP_BYTES = hkrb_pkg::BITMAP_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hkrb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                     i_cfg_data,
    input  logic [2:0]                     i_in_action,
    input  logic [7:0]                     i_in_key_code,
    input  logic [7:0]                     i_in_mod_bits,
    input  logic                           i_out_ready,
    input  hkrb_pkg::t_dp_cmd              i_cmd,
    output hkrb_pkg::t_dp_sts              o_sts,
    output logic                           o_out_valid,
    output logic [1:0]                     o_out_kind,
    output logic [3:0]                     o_out_byte_index,
    output logic [7:0]                     o_out_byte_value,
    output logic                           o_out_last,
    output logic [3:0]                     o_out_key_count,
    output logic [7:0]                     o_out_first_key,
    output logic                           o_out_key_pressed,
    output logic [7:0]                     o_out_mods
);
    import hkrb_pkg::*;

    localparam int BM_AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
    localparam int LB_AW = $clog2(BITMAP_BYTES + 1);
    localparam int CW    = (LB_AW > 3) ? LB_AW : 3;

    logic [7:0]    r_first_usage;
    logic [7:0]    r_report_id;
    logic [7:0]    r_slots [KEY_SLOTS];
    logic [7:0]    r_bitmap [BITMAP_BYTES];
    logic [7:0]    r_mods;
    logic [63:0]   r_last_boot;
    logic [7:0]    r_last_bm [BITMAP_BYTES+1];
    logic          r_out_valid;

    t_action       r_action;
    logic [7:0]    r_code;
    logic [7:0]    r_mbits;
    logic [CW-1:0] r_idx;
    logic [3:0]    r_cnt;
    logic [7:0]    r_fk;
    logic          r_seen;
    logic          r_pressed;
    logic          r_boot_diff;
    logic          r_bm_diff;
    t_kind         r_out_kind;
    logic [3:0]    r_out_index;
    logic [7:0]    r_out_value;
    logic          r_out_last;
    logic [3:0]    r_out_cnt;
    logic [7:0]    r_out_fk;
    logic          r_out_pr;
    logic [7:0]    r_out_mods;

    logic [7:0]       w_code_off;
    logic             w_in_rng;
    logic [BM_AW-1:0] w_code_byte;
    logic [2:0]       w_code_bit;
    logic [7:0]       w_mask;
    logic [CW-1:0]    w_idx_m1;
    logic [BM_AW-1:0] w_raddr;
    logic [7:0]       w_rdata;
    logic             w_found;
    logic             w_taken;
    logic [KEY_SLOTS-1:0] w_empty_oh;
    logic             w_pressed;
    logic [63:0]      w_boot;
    logic             w_boot_ne;
    logic [LB_AW-1:0] w_lb_addr;
    logic [7:0]       w_cmp_byte;
    logic             w_cmp_ne;
    logic [7:0]       w_fk;
    logic             w_out_free;

    assign w_code_off  = r_code - r_first_usage;
    assign w_in_rng    = (r_code >= r_first_usage) && (w_code_off[7:3] < 5'(BITMAP_BYTES));
    assign w_code_byte = w_code_off[3 +: BM_AW];
    assign w_code_bit  = w_code_off[2:0];
    assign w_mask      = 8'd1 << w_code_bit;
    assign w_idx_m1    = r_idx - CW'(1);

    // One bitmap read port, shared by the key update, the status scan and the report compare.
    always_comb begin
        if (i_cmd.exec) begin
            w_raddr = w_code_byte;
        end else if (i_cmd.cmp_step) begin
            w_raddr = w_idx_m1[BM_AW-1:0];
        end else begin
            w_raddr = r_idx[BM_AW-1:0];
        end
    end

    assign w_rdata = (int'(w_raddr) < BITMAP_BYTES) ? r_bitmap[w_raddr] : 8'd0;

    always_comb begin
        w_found    = 1'b0;
        w_taken    = 1'b0;
        w_empty_oh = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_slots[i] == r_code) begin
                w_found = 1'b1;
            end
            if (!w_taken && (r_slots[i] == 8'd0)) begin
                w_empty_oh[i] = 1'b1;
                w_taken       = 1'b1;
            end
        end
    end

    // Codes at or above the first usage are answered from the bitmap, lower ones from the slots.
    assign w_pressed = (r_code != 8'd0) &&
                       ((r_code >= r_first_usage) ? (w_in_rng && w_rdata[w_code_bit]) : w_found);

    always_comb begin
        w_boot       = '0;
        w_boot[7:0]  = r_mods;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            w_boot[8*(k+2) +: 8] = r_slots[k];
        end
    end

    assign w_boot_ne  = (w_boot != r_last_boot);
    assign w_lb_addr  = r_idx[LB_AW-1:0];
    assign w_cmp_byte = (r_idx == '0) ? r_report_id : w_rdata;
    assign w_cmp_ne   = (w_cmp_byte != r_last_bm[w_lb_addr]);
    assign w_fk       = ((8'(r_idx) << 3) | {5'd0, high_bit(w_rdata)}) + r_first_usage;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.action    = r_action;
        o_sts.out_free  = w_out_free;
        o_sts.boot_diff = r_boot_diff;
        o_sts.bm_diff   = r_bm_diff | (i_cmd.cmp_step & w_cmp_ne);
        o_sts.scan_end  = (r_idx == CW'(BITMAP_BYTES - 1));
        o_sts.boot_end  = (r_idx == CW'(BOOT_BYTES - 1));
        o_sts.bm_end    = (r_idx == CW'(BITMAP_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_usage <= FIRST_USAGE_RST;
            r_report_id   <= REPORT_ID_RST;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_slots[i] <= 8'd0;
            end
            for (int i = 0; i < BITMAP_BYTES; i++) begin
                r_bitmap[i] <= 8'd0;
            end
            for (int i = 0; i < BITMAP_BYTES + 1; i++) begin
                r_last_bm[i] <= 8'd0;
            end
            r_mods      <= 8'd0;
            r_last_boot <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FIRST_USAGE: r_first_usage <= i_cfg_data;
                    CFG_REPORT_ID:   r_report_id   <= i_cfg_data;
                endcase
            end
            if (i_cmd.exec) begin
                unique case (r_action)
                    ACT_KEY_DOWN: begin
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            if (!w_found && w_empty_oh[i]) begin
                                r_slots[i] <= r_code;
                            end
                        end
                        if (w_in_rng) begin
                            r_bitmap[w_code_byte] <= w_rdata | w_mask;
                        end
                    end
                    ACT_KEY_UP: begin
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            if (r_slots[i] == r_code) begin
                                r_slots[i] <= 8'd0;
                            end
                        end
                        if (w_in_rng) begin
                            r_bitmap[w_code_byte] <= w_rdata & ~w_mask;
                        end
                    end
                    ACT_CLEAR_KEYS: begin
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            r_slots[i] <= 8'd0;
                        end
                        for (int i = 0; i < BITMAP_BYTES; i++) begin
                            r_bitmap[i] <= 8'd0;
                        end
                    end
                    ACT_ADD_MODS:    r_mods <= r_mods | r_mbits;
                    ACT_REMOVE_MODS: r_mods <= r_mods & ~r_mbits;
                    ACT_SET_MODS:    r_mods <= r_mbits;
                    ACT_SEND: begin
                        if (w_boot_ne) begin
                            r_last_boot <= w_boot;
                        end
                    end
                    ACT_STATUS: begin
                    end
                endcase
            end
            // The copy is refreshed while it is compared; emission then reads the copy.
            if (i_cmd.cmp_step) begin
                r_last_bm[w_lb_addr] <= w_cmp_byte;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= t_action'(i_in_action);
            r_code   <= i_in_key_code;
            r_mbits  <= i_in_mod_bits;
        end
        if (i_cmd.exec) begin
            r_cnt       <= 4'd0;
            r_fk        <= 8'd0;
            r_seen      <= 1'b0;
            r_pressed   <= w_pressed;
            r_boot_diff <= w_boot_ne;
            r_bm_diff   <= 1'b0;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_step && (w_rdata != 8'd0)) begin
            if (r_cnt != 4'd15) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (!r_seen) begin
                r_seen <= 1'b1;
                r_fk   <= w_fk;
            end
        end
        if (i_cmd.cmp_step && w_cmp_ne) begin
            r_bm_diff <= 1'b1;
        end
        if (i_cmd.emit) begin
            unique case (i_cmd.emit_kind)
                KIND_BOOT: begin
                    r_out_kind  <= KIND_BOOT;
                    r_out_index <= 4'(r_idx);
                    r_out_value <= r_last_boot[{r_idx[2:0], 3'b000} +: 8];
                    r_out_last  <= (r_idx == CW'(BOOT_BYTES - 1)) && !r_bm_diff;
                    r_out_cnt   <= 4'd0;
                    r_out_fk    <= 8'd0;
                    r_out_pr    <= 1'b0;
                    r_out_mods  <= 8'd0;
                end
                KIND_BITMAP: begin
                    r_out_kind  <= KIND_BITMAP;
                    r_out_index <= 4'(r_idx);
                    r_out_value <= r_last_bm[w_lb_addr];
                    r_out_last  <= (r_idx == CW'(BITMAP_BYTES));
                    r_out_cnt   <= 4'd0;
                    r_out_fk    <= 8'd0;
                    r_out_pr    <= 1'b0;
                    r_out_mods  <= 8'd0;
                end
                default: begin
                    r_out_kind  <= KIND_STATUS;
                    r_out_index <= 4'd0;
                    r_out_value <= 8'd0;
                    r_out_last  <= 1'b1;
                    r_out_cnt   <= r_cnt;
                    r_out_fk    <= r_fk;
                    r_out_pr    <= r_pressed;
                    r_out_mods  <= r_mods;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_kind        = r_out_kind;
    assign o_out_byte_index  = r_out_index;
    assign o_out_byte_value  = r_out_value;
    assign o_out_last        = r_out_last;
    assign o_out_key_count   = r_out_cnt;
    assign o_out_first_key   = r_out_fk;
    assign o_out_key_pressed = r_out_pr;
    assign o_out_mods        = r_out_mods;

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result loaded while the previous one was still held");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_STATUS)) |-> r_out_last)
        else $error("status result without end-of-run flag");

    a_boot_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.exec && (r_action == ACT_SEND)) |-> (r_last_boot == w_boot))
        else $error("boot report copy not refreshed by send");

endmodule

// File: hw/rtl/hkrb_ctrl.sv
// Sequencing state machine of the report builder.
module hkrb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hkrb_pkg::t_dp_sts i_sts,
    output hkrb_pkg::t_dp_cmd o_cmd
);
    import hkrb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (i_sts.action == ACT_STATUS) begin
                    n_state = ST_SCAN;
                end else if (i_sts.action == ACT_SEND) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CMP: begin
                if (i_sts.bm_end) begin
                    priority if (i_sts.boot_diff) begin
                        n_state = ST_BOOT;
                    end else if (i_sts.bm_diff) begin
                        n_state = ST_BM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_BOOT: begin
                if (i_sts.out_free && i_sts.boot_end) begin
                    n_state = i_sts.bm_diff ? ST_BM : ST_IDLE;
                end
            end
            ST_BM: begin
                if (i_sts.out_free && i_sts.bm_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.emit_kind = KIND_STATUS;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec    = 1'b1;
                o_cmd.idx_clr = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.idx_inc   = 1'b1;
            end
            ST_STATUS: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_kind = KIND_STATUS;
            end
            ST_CMP: begin
                o_cmd.cmp_step = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                o_cmd.idx_clr  = i_sts.bm_end;
            end
            ST_BOOT: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_kind = KIND_BOOT;
                o_cmd.idx_inc   = i_sts.out_free;
                o_cmd.idx_clr   = i_sts.out_free && i_sts.boot_end;
            end
            ST_BM: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_kind = KIND_BITMAP;
                o_cmd.idx_inc   = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_EXEC))
        else $error("transfer accepted without moving to execute");

endmodule

// File: test/tb_hid_keyboard_report_builder.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HID keyboard report builder: random and directed events against a predictor.
module tb_hid_keyboard_report_builder;
    import hkrb_pkg::*;

    localparam int NSLOT  = KEY_SLOTS_DEF;
    localparam int NBM    = BITMAP_BYTES_DEF;
    localparam int SETTLE = 60;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        t_action    act;
        logic [7:0] code;
        logic [7:0] mask;
    } t_key_event;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] idx;
        logic [7:0] val;
        logic       last;
        logic [3:0] cnt;
        logic [7:0] fk;
        logic       pr;
        logic [7:0] md;
    } t_report_res;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]           i_cfg_data;

    hkrb_in_if  key_if ();
    hkrb_out_if res_if ();

    hid_keyboard_report_builder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_key_if   (key_if),
        .o_res_if   (res_if)
    );

    // Predicted state of the block.
    logic [7:0] slot_m    [NSLOT];
    logic [7:0] bitmap_m  [NBM];
    logic [7:0] mods_m;
    logic [7:0] boot_sent [BOOT_BYTES];
    logic [7:0] bm_sent   [NBM+1];
    logic [7:0] first_usage_m;
    logic [7:0] report_id_m;

    t_key_event  event_q   [$];
    t_report_res awaited_q [$];
    int          n_queued = 0;
    int          n_taken  = 0;
    int          n_fail   = 0;
    bit          key_xfer = 1'b0;
    bit          rx_hold  = 1'b0;
    int          gap_left = 0;
    int          burst_left = 1;
    logic [31:0] rx_cyc = '0;

    // First usage and report id for each configuration phase.
    logic [7:0] cfg_plan [6][2] = '{'{8'd0, 8'd0}, '{8'd4, 8'd6}, '{8'd250, 8'd133},
                                    '{8'd255, 8'd255}, '{8'd128, 8'd127}, '{8'd17, 8'd1}};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit bitmap_slot(input logic [7:0] code, output int byte_no,
                                       output int bit_no);
        int ofs;
        byte_no = 0;
        bit_no  = 0;
        if (code < first_usage_m) begin
            return 1'b0;
        end
        ofs = int'(code) - int'(first_usage_m);
        if ((ofs >> 3) >= NBM) begin
            return 1'b0;
        end
        byte_no = ofs >> 3;
        bit_no  = ofs & 7;
        return 1'b1;
    endfunction

    // Applies one event to the predicted state and queues the results it should produce.
    task automatic predict_event(input t_key_event ev);
        int          bn, kn, empty_at, cnt, hb;
        logic        found, seen, pr, differs;
        logic [7:0]  boot [BOOT_BYTES];
        logic [7:0]  bmr  [NBM+1];
        logic [7:0]  fk;
        t_report_res outs [$];
        t_report_res r;
        case (ev.act)
            ACT_KEY_DOWN: begin
                found    = 1'b0;
                empty_at = -1;
                // A zero code matches the first empty slot, so it never takes one.
                for (int i = 0; i < NSLOT && !found; i++) begin
                    if (slot_m[i] == ev.code) begin
                        found = 1'b1;
                    end else if (empty_at < 0 && slot_m[i] == 8'd0) begin
                        empty_at = i;
                    end
                end
                if (!found && empty_at >= 0) begin
                    slot_m[empty_at] = ev.code;
                end
                if (bitmap_slot(ev.code, bn, kn)) begin
                    bitmap_m[bn][kn] = 1'b1;
                end
            end
            ACT_KEY_UP: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (slot_m[i] == ev.code) begin
                        slot_m[i] = 8'd0;
                    end
                end
                if (bitmap_slot(ev.code, bn, kn)) begin
                    bitmap_m[bn][kn] = 1'b0;
                end
            end
            ACT_CLEAR_KEYS: begin
                foreach (slot_m[i]) slot_m[i] = 8'd0;
                foreach (bitmap_m[i]) bitmap_m[i] = 8'd0;
            end
            ACT_ADD_MODS: begin
                mods_m = mods_m | ev.mask;
            end
            ACT_REMOVE_MODS: begin
                mods_m = mods_m & ~ev.mask;
            end
            ACT_SET_MODS: begin
                mods_m = ev.mask;
            end
            ACT_SEND: begin
                boot[0] = mods_m;
                boot[1] = 8'd0;
                for (int i = 0; i < NSLOT; i++) boot[i+2] = slot_m[i];
                differs = 1'b0;
                for (int i = 0; i < BOOT_BYTES; i++) begin
                    if (boot[i] != boot_sent[i]) differs = 1'b1;
                end
                if (differs) begin
                    for (int i = 0; i < BOOT_BYTES; i++) begin
                        boot_sent[i] = boot[i];
                        r      = '0;
                        r.kind = KIND_BOOT;
                        r.idx  = 4'(i);
                        r.val  = boot[i];
                        outs.push_back(r);
                    end
                end
                bmr[0] = report_id_m;
                for (int i = 0; i < NBM; i++) bmr[i+1] = bitmap_m[i];
                differs = 1'b0;
                for (int i = 0; i <= NBM; i++) begin
                    if (bmr[i] != bm_sent[i]) differs = 1'b1;
                end
                if (differs) begin
                    for (int i = 0; i <= NBM; i++) begin
                        bm_sent[i] = bmr[i];
                        r      = '0;
                        r.kind = KIND_BITMAP;
                        r.idx  = 4'(i);
                        r.val  = bmr[i];
                        outs.push_back(r);
                    end
                end
            end
            default: begin
                cnt  = 0;
                fk   = 8'd0;
                seen = 1'b0;
                pr   = 1'b0;
                for (int i = 0; i < NBM; i++) begin
                    if (bitmap_m[i] != 8'd0) begin
                        cnt++;
                        if (!seen) begin
                            seen = 1'b1;
                            hb   = 0;
                            for (int b = 0; b < 8; b++) begin
                                if (bitmap_m[i][b]) hb = b;
                            end
                            // The usage wraps when the first usage moved after the keys went down.
                            fk = 8'(i * 8 + hb + int'(first_usage_m));
                        end
                    end
                end
                if (cnt > 15) cnt = 15;
                if (ev.code != 8'd0) begin
                    if (ev.code >= first_usage_m) begin
                        if (bitmap_slot(ev.code, bn, kn)) pr = bitmap_m[bn][kn];
                    end else begin
                        for (int i = 0; i < NSLOT; i++) begin
                            if (slot_m[i] == ev.code) pr = 1'b1;
                        end
                    end
                end
                r      = '0;
                r.kind = KIND_STATUS;
                r.cnt  = 4'(cnt);
                r.fk   = fk;
                r.pr   = pr;
                r.md   = mods_m;
                outs.push_back(r);
            end
        endcase
        if (outs.size() > 0) begin
            r      = outs.pop_back();
            r.last = 1'b1;
            outs.push_back(r);
        end
        foreach (outs[i]) awaited_q.push_back(outs[i]);
    endtask

    task automatic note_failure(input string why, input t_report_res want,
                                input t_report_res got);
        n_fail++;
        if (n_fail <= 10) begin
            $display("%0t %s: expected kind=%0d idx=%0d val=%h last=%b cnt=%0d fk=%h pr=%b md=%h",
                     $time, why, want.kind, want.idx, want.val, want.last, want.cnt, want.fk,
                     want.pr, want.md);
            $display("    got kind=%0d idx=%0d val=%h last=%b cnt=%0d fk=%h pr=%b md=%h",
                     got.kind, got.idx, got.val, got.last, got.cnt, got.fk, got.pr, got.md);
        end
    endtask

    task automatic queue_event(input t_action act, input logic [7:0] code,
                               input logic [7:0] mask);
        t_key_event ev;
        ev.act  = act;
        ev.code = code;
        ev.mask = mask;
        event_q.push_back(ev);
        n_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_FIRST_USAGE) begin
            first_usage_m = data;
        end else begin
            report_id_m = data;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every event has been taken and every result has arrived, then lets the
    // block finish any event that produces no result.
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (n_taken != n_queued || awaited_q.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Sender: bursts of events separated by random gaps, with noise on the idle payload.
    always @(negedge i_clk) begin
        t_key_event ev;
        if (!i_rst_n) begin
            key_if.valid <= 1'b0;
        end else if (key_if.valid && !key_xfer) begin
            // The offered event has not been taken yet, so it stays on the bus.
        end else if (gap_left > 0 || event_q.size() == 0) begin
            if (gap_left > 0) gap_left--;
            key_if.valid    <= 1'b0;
            key_if.action   <= 3'($urandom);
            key_if.key_code <= 8'($urandom);
            key_if.mod_bits <= 8'($urandom);
        end else begin
            ev = event_q.pop_front();
            key_if.valid    <= 1'b1;
            key_if.action   <= ev.act;
            key_if.key_code <= ev.code;
            key_if.mod_bits <= ev.mask;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
    end

    // Receiver: cycles through always ready, random stalls, a fixed pattern and heavy stalls.
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_hold) begin
            res_if.ready <= 1'b0;
        end else begin
            case (rx_cyc[7:6])
                2'd0:    res_if.ready <= 1'b1;
                2'd1:    res_if.ready <= ($urandom_range(0, 2) != 0);
                2'd2:    res_if.ready <= ((rx_cyc % 5) >= 2);
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Long receiver hold-off so that queued results back up into the input.
    initial begin
        int held;
        held = 0;
        wait (n_taken >= 60);
        rx_hold = 1'b1;
        while (held < HOLD_CYCLES) begin
            @(posedge i_clk);
            held++;
        end
        rx_hold = 1'b0;
    end

    // Monitor: predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin
        t_key_event  ev;
        t_report_res got;
        t_report_res want;
        key_xfer = 1'b0;
        if (i_rst_n) begin
            if (key_if.valid && key_if.ready) begin
                key_xfer = 1'b1;
                n_taken++;
                ev.act  = t_action'(key_if.action);
                ev.code = key_if.key_code;
                ev.mask = key_if.mod_bits;
                predict_event(ev);
            end
            if (res_if.valid && res_if.ready) begin
                got = {res_if.result_kind, res_if.byte_index, res_if.byte_value,
                       res_if.last_of_run, res_if.key_count, res_if.first_key,
                       res_if.key_pressed, res_if.mods};
                if (awaited_q.size() == 0) begin
                    note_failure("result with nothing awaited", '0, got);
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want) note_failure("result mismatch", want, got);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("[hid_keyboard_report_builder] ERROR");
        $finish;
    end

    initial begin
        int         pick;
        t_action    act;
        logic [7:0] code;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_FIRST_USAGE;
        i_cfg_data      = 8'd0;
        key_if.valid    = 1'b0;
        key_if.action   = ACT_STATUS;
        key_if.key_code = 8'd0;
        key_if.mod_bits = 8'd0;
        res_if.ready    = 1'b0;
        first_usage_m   = FIRST_USAGE_RST;
        report_id_m     = REPORT_ID_RST;
        mods_m          = 8'd0;
        foreach (slot_m[i]) slot_m[i] = 8'd0;
        foreach (bitmap_m[i]) bitmap_m[i] = 8'd0;
        foreach (boot_sent[i]) boot_sent[i] = 8'd0;
        foreach (bm_sent[i]) bm_sent[i] = 8'd0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, at the reset configuration.
        queue_event(ACT_STATUS, 8'h00, 8'h00);      // empty bitmap
        queue_event(ACT_SEND, 8'h00, 8'h00);        // only the report id differs
        queue_event(ACT_SEND, 8'h00, 8'h00);        // nothing changed
        queue_event(ACT_KEY_DOWN, 8'h04, 8'h00);    // first bitmap bit
        queue_event(ACT_KEY_DOWN, 8'h7B, 8'h00);    // last bitmap bit
        queue_event(ACT_KEY_DOWN, 8'h7C, 8'h00);    // past the bitmap
        queue_event(ACT_KEY_DOWN, 8'h02, 8'h00);    // below the first usage
        queue_event(ACT_KEY_DOWN, 8'h00, 8'h00);    // no key
        queue_event(ACT_KEY_DOWN, 8'h04, 8'h00);    // already held
        queue_event(ACT_KEY_DOWN, 8'h10, 8'h00);
        queue_event(ACT_KEY_DOWN, 8'h11, 8'h00);    // slots now full
        queue_event(ACT_KEY_DOWN, 8'h12, 8'h00);    // dropped from the slots
        queue_event(ACT_SET_MODS, 8'h00, 8'hA5);
        queue_event(ACT_ADD_MODS, 8'h00, 8'h5A);
        queue_event(ACT_REMOVE_MODS, 8'h00, 8'h81);
        queue_event(ACT_STATUS, 8'h02, 8'h00);
        queue_event(ACT_STATUS, 8'h7C, 8'h00);
        queue_event(ACT_STATUS, 8'h12, 8'h00);
        queue_event(ACT_SEND, 8'hFF, 8'hFF);
        queue_event(ACT_KEY_UP, 8'h04, 8'h00);
        queue_event(ACT_KEY_UP, 8'h02, 8'h00);
        queue_event(ACT_STATUS, 8'h04, 8'h00);
        queue_event(ACT_CLEAR_KEYS, 8'h00, 8'h00);
        queue_event(ACT_SEND, 8'h00, 8'h00);
        queue_event(ACT_STATUS, 8'hFF, 8'hFF);
        wait_drained();

        // Random phases, each under its own configuration. Keys are left held across a
        // change of the first usage, so the opening status query sees shifted usages.
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_FIRST_USAGE, cfg_plan[p][0]);
            write_reg(CFG_REPORT_ID, cfg_plan[p][1]);
            queue_event(ACT_STATUS, 8'($urandom), 8'($urandom));
            repeat (30) begin
                pick = $urandom_range(0, 99);
                if (pick < 34)      act = ACT_KEY_DOWN;
                else if (pick < 52) act = ACT_KEY_UP;
                else if (pick < 55) act = ACT_CLEAR_KEYS;
                else if (pick < 60) act = ACT_ADD_MODS;
                else if (pick < 64) act = ACT_REMOVE_MODS;
                else if (pick < 68) act = ACT_SET_MODS;
                else if (pick < 84) act = ACT_SEND;
                else                act = ACT_STATUS;
                // Mostly a small pool near the first usage, so keys repeat and get released.
                pick = $urandom_range(0, 9);
                if (pick < 7)       code = 8'(first_usage_m + $urandom_range(0, 20));
                else if (pick < 8)  code = 8'(first_usage_m + $urandom_range(100, 127));
                else                code = 8'($urandom);
                queue_event(act, code, 8'($urandom));
            end
            queue_event(ACT_KEY_DOWN, 8'(first_usage_m + 8'd3), 8'h00);
            queue_event(ACT_SEND, 8'h00, 8'h00);
            wait_drained();
        end

        if (n_fail == 0) begin
            $display("[hid_keyboard_report_builder] OK");
        end else begin
            $display("[hid_keyboard_report_builder] ERROR");
        end
        $finish;
    end

endmodule
